// ===== hw/rtl/spdc_pkg.sv =====
`timescale 1ns / 1ps

package spdc_pkg;

    // Field widths of the request, result and configuration port.
    localparam int PULSE_W    = 12;
    localparam int CMD_W      = 16;
    localparam int DUTY_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Defaults for the timer resolution and the servo frame period.
    localparam int DUTY_BITS_DEF = 14;
    localparam int PERIOD_US_DEF = 20000;

    // Largest compare value the duty field can carry.
    localparam int unsigned DUTY_FIELD_MAX = 32767;

    // Configuration values after reset.
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = 12'd1000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST    = 12'd2000;
    localparam logic [PULSE_W-1:0] CENTER_PULSE_RST = 12'd0;
    localparam logic               INVERT_RST       = 1'b0;
    localparam logic               DEFAULT_EN_RST   = 1'b1;
    localparam logic [PULSE_W-1:0] START_PULSE_RST  = 12'd0;

    typedef logic [PULSE_W-1:0] pulse_t;

    // Command codes.
    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_SET_PULSE  = 2'd1,
        OP_SET_ENABLE = 2'd2
    } opcode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE    = 3'd0,
        REG_MAX_PULSE    = 3'd1,
        REG_CENTER_PULSE = 3'd2,
        REG_INVERT       = 3'd3,
        REG_DEFAULT_EN   = 3'd4,
        REG_START_PULSE  = 3'd5
    } cfg_reg_t;

endpackage

// ===== hw/rtl/servo_pulse_duty_controller_top.sv =====
`timescale 1ns / 1ps

// Servo pulse controller: takes start, set-pulse and set-enable requests, keeps the
// servo position as a pulse width clamped to the travel range (optionally mirrored
// about neutral) and returns the timer compare value round(pulse * 2^DUTY_BITS /
// PERIOD_US), or 0 while disabled or without a position. One request is accepted
// per clock cycle while the request side is not stalled; a result is offered once
// its request has moved from the request register through the state stage and the
// reciprocal multiply for the period division into the result register, which
// takes the corrected and saturated duty. A stalled result holds the stages behind
// it, and the request side stalls once all four registers are full. A set-enable
// request that does not change the enable state gives no result, and neither does
// the unused opcode.
module servo_pulse_duty_controller_top #(
    parameter int DUTY_BITS = spdc_pkg::DUTY_BITS_DEF,
    parameter int PERIOD_US = spdc_pkg::PERIOD_US_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [spdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Request channel
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [1:0]                          opcode,
    input  logic signed [spdc_pkg::CMD_W-1:0]   command_value,
    // Result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [spdc_pkg::DUTY_W-1:0]         duty_value,
    output spdc_pkg::pulse_t                    output_pulse_us,
    output logic                                enabled_now,
    output logic                                enable_report
);
    import spdc_pkg::*;

    // Division by the period is a multiply by a truncated reciprocal of 2^SHIFT / P.
    // The estimate is low by at most one, which the last stage corrects.
    localparam int SHIFT  = DUTY_BITS + 14;
    localparam int M_W    = DUTY_BITS + 3;
    localparam int PROD_W = PULSE_W + M_W;
    localparam int SUM_W  = PROD_W + DUTY_BITS + 1;
    localparam int Q_W    = SUM_W - SHIFT;
    localparam int N_W    = PULSE_W + DUTY_BITS + 1;
    localparam int P_W    = $clog2(PERIOD_US + 1);
    localparam int CMP_W  = Q_W + P_W + 1;

    localparam logic [63:0]      RECIP64  = (64'd1 << SHIFT) / PERIOD_US;
    localparam logic [M_W-1:0]   RECIP    = M_W'(RECIP64);
    localparam logic [SUM_W-1:0] ROUND_K  = SUM_W'(64'(PERIOD_US / 2) * RECIP64);
    localparam logic [N_W-1:0]   HALF_P   = N_W'(PERIOD_US / 2);
    localparam logic [P_W-1:0]   PERIOD_C = P_W'(PERIOD_US);
    localparam logic [63:0]      FULL64   = 64'd1 << DUTY_BITS;
    localparam logic [63:0]      CAP64    = (FULL64 > 64'(DUTY_FIELD_MAX)) ?
                                            64'(DUTY_FIELD_MAX) : FULL64;
    localparam logic [Q_W:0]     DUTY_CAP = (Q_W + 1)'(CAP64);

    // Configuration registers
    pulse_t min_pulse_reg;
    pulse_t max_pulse_reg;
    pulse_t center_pulse_reg;
    logic   invert_reg;
    logic   default_en_reg;
    pulse_t start_pulse_reg;

    // Servo state
    logic   enabled_reg;
    logic   enabled_next;
    logic   has_pos_reg;
    logic   has_pos_next;
    pulse_t cur_pulse_reg;
    pulse_t cur_pulse_next;

    // Stage 1: request register
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    opcode_t                  s1_op_reg;
    logic signed [CMD_W-1:0]  s1_value_reg;

    // Stage 2: state after the request
    logic   s2_valid_reg;
    pulse_t s2_pulse_reg;
    logic   s2_en_reg;
    logic   s2_report_reg;
    logic   s2_active_reg;

    // Stage 3: quotient estimate
    logic           s3_valid_reg;
    logic [Q_W-1:0] s3_qest_reg;
    pulse_t         s3_pulse_reg;
    logic           s3_en_reg;
    logic           s3_report_reg;
    logic           s3_active_reg;

    // Result register
    logic                res_valid_reg;
    logic [DUTY_W-1:0]   duty_reg;
    pulse_t              res_pulse_reg;
    logic                res_en_reg;
    logic                res_report_reg;

    // Handshake and flow control
    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_fire;
    logic cmd_accept;
    logic has_result;
    logic report;

    // Placement logic
    pulse_t              lo_end;
    pulse_t              hi_end;
    logic [PULSE_W:0]    mid_sum;
    pulse_t              center_raw;
    pulse_t              neutral;
    logic signed [16:0]  place_in;
    pulse_t              clamped;
    logic signed [14:0]  mirrored;
    pulse_t              placed;

    // Duty arithmetic
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  est_sum;
    logic [N_W-1:0]    numer;
    logic [CMP_W-1:0]  back_prod;
    logic [Q_W:0]      quot;
    logic [Q_W:0]      quot_sat;

    function automatic pulse_t clamp_pulse(
        input logic signed [16:0] v,
        input pulse_t             lo,
        input pulse_t             hi
    );
        pulse_t r;
        if (v < $signed({5'b0, lo}))
        begin
            r = lo;
        end
        else if (v > $signed({5'b0, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[PULSE_W-1:0];
        end
        return r;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg    <= MIN_PULSE_RST;
            max_pulse_reg    <= MAX_PULSE_RST;
            center_pulse_reg <= CENTER_PULSE_RST;
            invert_reg       <= INVERT_RST;
            default_en_reg   <= DEFAULT_EN_RST;
            start_pulse_reg  <= START_PULSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_PULSE:    min_pulse_reg    <= cfg_data;
                REG_MAX_PULSE:    max_pulse_reg    <= cfg_data;
                REG_CENTER_PULSE: center_pulse_reg <= cfg_data;
                REG_INVERT:       invert_reg       <= cfg_data[0];
                REG_DEFAULT_EN:   default_en_reg   <= cfg_data[0];
                REG_START_PULSE:  start_pulse_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Flow control: each stage moves when the stage after it can take its request.
    // A request that gives no result leaves stage 1 without waiting.
    assign out_free   = !res_valid_reg || !res_stall;
    assign s3_free    = !s3_valid_reg || out_free;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_fire    = s1_valid_reg && (!has_result || s2_free);
    assign cmd_stall  = s1_valid_reg && !s1_fire;
    assign cmd_accept = cmd_valid && !cmd_stall;

    // Travel range and neutral point
    always_comb
    begin
        lo_end     = (min_pulse_reg < max_pulse_reg) ? min_pulse_reg : max_pulse_reg;
        hi_end     = (min_pulse_reg < max_pulse_reg) ? max_pulse_reg : min_pulse_reg;
        mid_sum    = {1'b0, min_pulse_reg} + {1'b0, max_pulse_reg};
        center_raw = (center_pulse_reg == '0) ? mid_sum[PULSE_W:1] : center_pulse_reg;
        neutral    = clamp_pulse({5'b0, center_raw}, lo_end, hi_end);
    end

    // Clamp the commanded or start pulse, then mirror about neutral if inverted.
    always_comb
    begin
        if (s1_op_reg == OP_START)
        begin
            place_in = {5'b0, start_pulse_reg};
        end
        else
        begin
            place_in = 17'(s1_value_reg);
        end
        clamped  = clamp_pulse(place_in, lo_end, hi_end);
        mirrored = $signed({2'b0, neutral, 1'b0}) - $signed({3'b0, clamped});
        if (invert_reg)
        begin
            placed = clamp_pulse(17'(mirrored), lo_end, hi_end);
        end
        else
        begin
            placed = clamped;
        end
    end

    // Next servo state and whether the request gives a result
    always_comb
    begin
        enabled_next   = enabled_reg;
        has_pos_next   = has_pos_reg;
        cur_pulse_next = cur_pulse_reg;
        has_result     = 1'b0;
        report         = 1'b0;
        case (s1_op_reg)
            OP_START:
            begin
                enabled_next = default_en_reg;
                has_result   = 1'b1;
                report       = 1'b1;
                if (start_pulse_reg != '0)
                begin
                    cur_pulse_next = placed;
                    has_pos_next   = 1'b1;
                end
                else
                begin
                    cur_pulse_next = '0;
                    has_pos_next   = 1'b0;
                end
            end
            OP_SET_PULSE:
            begin
                cur_pulse_next = placed;
                has_pos_next   = 1'b1;
                has_result     = 1'b1;
            end
            OP_SET_ENABLE:
            begin
                if ((s1_value_reg != '0) != enabled_reg)
                begin
                    enabled_next = (s1_value_reg != '0);
                    has_result   = 1'b1;
                    report       = 1'b1;
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // Reciprocal multiply for the quotient estimate
    always_comb
    begin
        prod    = PROD_W'(s2_pulse_reg) * PROD_W'(RECIP);
        est_sum = {prod, DUTY_BITS'(0)} + ROUND_K;
    end

    // Correct the estimate by one where the remainder reaches a full period, then saturate.
    always_comb
    begin
        numer     = {s3_pulse_reg, DUTY_BITS'(0)} + HALF_P;
        back_prod = CMP_W'(s3_qest_reg) * CMP_W'(PERIOD_C) + CMP_W'(PERIOD_C);
        if (CMP_W'(numer) >= back_prod)
        begin
            quot = {1'b0, s3_qest_reg} + (Q_W + 1)'(1);
        end
        else
        begin
            quot = {1'b0, s3_qest_reg};
        end
        quot_sat = (quot > DUTY_CAP) ? DUTY_CAP : quot;
    end

    // Request register valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            enabled_reg   <= 1'b0;
            has_pos_reg   <= 1'b0;
            cur_pulse_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_fire)
            begin
                enabled_reg   <= enabled_next;
                has_pos_reg   <= has_pos_next;
                cur_pulse_reg <= cur_pulse_next;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_fire && has_result;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_op_reg    <= opcode_t'(opcode);
            s1_value_reg <= command_value;
        end
        if (s2_free)
        begin
            s2_pulse_reg  <= cur_pulse_next;
            s2_en_reg     <= enabled_next;
            s2_report_reg <= report;
            s2_active_reg <= enabled_next && has_pos_next;
        end
        if (s3_free)
        begin
            s3_qest_reg   <= est_sum[SUM_W-1:SHIFT];
            s3_pulse_reg  <= s2_pulse_reg;
            s3_en_reg     <= s2_en_reg;
            s3_report_reg <= s2_report_reg;
            s3_active_reg <= s2_active_reg;
        end
        if (out_free)
        begin
            duty_reg       <= s3_active_reg ? DUTY_W'(quot_sat) : '0;
            res_pulse_reg  <= s3_pulse_reg;
            res_en_reg     <= s3_en_reg;
            res_report_reg <= s3_report_reg;
        end
    end

    assign res_valid       = res_valid_reg;
    assign duty_value      = duty_reg;
    assign output_pulse_us = res_pulse_reg;
    assign enabled_now     = res_en_reg;
    assign enable_report   = res_report_reg;

endmodule

// ===== hw/rtl/spdc_checker.sv =====
`timescale 1ns / 1ps

module spdc_checker #(
    parameter int DUTY_BITS = spdc_pkg::DUTY_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic [spdc_pkg::DUTY_W-1:0]  duty_value,
    input spdc_pkg::pulse_t             output_pulse_us,
    input logic                         enabled_now
);
    import spdc_pkg::*;

    localparam logic [63:0]       FULL64   = 64'd1 << DUTY_BITS;
    localparam logic [63:0]       CAP64    = (FULL64 > 64'(DUTY_FIELD_MAX)) ?
                                             64'(DUTY_FIELD_MAX) : FULL64;
    localparam logic [DUTY_W-1:0] DUTY_CAP = DUTY_W'(CAP64);

    // A result that is stalled stays offered with the same contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(duty_value)
            && $stable(output_pulse_us) && $stable(enabled_now))
        else $error("stalled result changed");

    // The compare value never exceeds one full timer period.
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> duty_value <= DUTY_CAP)
        else $error("duty above full period");

    // A disabled servo gets no drive.
    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !enabled_now |-> duty_value == '0)
        else $error("duty nonzero while disabled");

    // A zero pulse always means a zero compare value.
    a_zero_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && output_pulse_us == '0 |-> duty_value == '0)
        else $error("duty nonzero for zero pulse");

endmodule

bind servo_pulse_duty_controller_top spdc_checker #(.DUTY_BITS(DUTY_BITS)) u_spdc_checker (.*);
